[hw/rtl/spdc_pkg.sv]
// ----------------------------------------------------------------------------
// spdc_pkg
// Shared types, constants and helpers for the sample packet deframer.
// ----------------------------------------------------------------------------
package spdc_pkg;

   localparam int HEADER_BYTES_DEFAULT       = 12;
   localparam int SAMPLES_PER_PACKET_DEFAULT = 512;
   localparam int QUEUE_DEPTH_DEFAULT        = 4;

   // Header bytes that carry the time stamp.
   localparam int TIME_BYTES = 10;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TIME_INC   = 2'd0;
   localparam logic [1:0] CSR_OFFSET     = 2'd1;
   localparam logic [1:0] CSR_EXP_LENGTH = 2'd2;

   // Result kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Packet status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_TIME = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

   // One unit of work handed from the front to the back.
   typedef struct packed {
      logic                              has_sample;
      logic [15:0]                       raw;
      logic [9:0]                        index;
      logic                              has_status;
      logic [12:0]                       count;
      logic [TIME_BYTES-1:0][7:0]        hdr;
   } entry_type;

   // Day of year of the first of a month, counted from March.
   function automatic logic [8:0] spdc_doy(input logic [3:0] mp);
      logic [8:0] d;
      case (mp)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

[hw/rtl/spdc_front.sv]
// ----------------------------------------------------------------------------
// spdc_front
// Tracks the byte position, collects header bytes and pairs sample bytes.
// ----------------------------------------------------------------------------
module spdc_front import spdc_pkg::*; #(
   parameter int HEADER_BYTES       = HEADER_BYTES_DEFAULT,
   parameter int SAMPLES_PER_PACKET = SAMPLES_PER_PACKET_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       end_of_packet,
   output logic       push,
   output entry_type  entry
);

   localparam logic [11:0] POS_MAX = 12'd4095;
   localparam logic [11:0] HDR_LEN = 12'(HEADER_BYTES);
   localparam logic [10:0] SPP     = 11'(SAMPLES_PER_PACKET);

   logic [11:0] pos_ff, pos_in;
   logic [7:0]  hold_ff, hold_in;
   logic [TIME_BYTES-1:0][7:0] hdr_ff;
   logic [TIME_BYTES-1:0][7:0] hdr_now;
   logic [11:0] rel;
   logic        in_samples;
   logic        sample_ok;

   assign in_samples = pos_ff >= HDR_LEN;
   assign rel        = pos_ff - HDR_LEN;
   assign sample_ok  = in_samples && rel[0] && (rel[11:1] < SPP);

   // The current byte is already part of the header a short packet decodes.
   always_comb begin
      for (int i = 0; i < TIME_BYTES; i++) begin
         hdr_now[i] = (pos_ff == 12'(i)) ? data_byte : hdr_ff[i];
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      hold_in = hold_ff;
      if (accept) begin
         if (in_samples && !rel[0]) begin
            hold_in = data_byte;
         end
         if (end_of_packet) begin
            pos_in  = '0;
            hold_in = '0;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hold_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_now;
      end
   end

   assign push             = accept && (sample_ok || end_of_packet);
   assign entry.has_sample = sample_ok;
   assign entry.raw        = {hold_ff, data_byte};
   assign entry.index      = rel[10:1];
   assign entry.has_status = end_of_packet;
   assign entry.count      = {1'b0, pos_ff} + 13'd1;
   assign entry.hdr        = hdr_now;

endmodule

[hw/rtl/spdc_queue.sv]
// ----------------------------------------------------------------------------
// spdc_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module spdc_queue import spdc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type pop_data,
   output logic      full,
   output logic      empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full     = cnt_ff == CNT_FULL;
   assign empty    = cnt_ff == '0;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue read while empty");

endmodule

[hw/rtl/spdc_back.sv]
// ----------------------------------------------------------------------------
// spdc_back
// Emits sample results, decodes the header time and checks each packet.
// ----------------------------------------------------------------------------
module spdc_back import spdc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        time_increment_us,
   input  logic [15:0]        offset_value,
   input  logic [11:0]        expected_length,
   input  logic               q_empty,
   input  entry_type          q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic signed [16:0] rsp_sample_value,
   output logic [9:0]         rsp_sample_index,
   output logic [1:0]         rsp_packet_status,
   output logic [62:0]        rsp_packet_time_us,
   output logic               rsp_last_of_run
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SMP  = 3'd1;
   localparam logic [2:0] ST_D0   = 3'd2;
   localparam logic [2:0] ST_D1   = 3'd3;
   localparam logic [2:0] ST_D2   = 3'd4;
   localparam logic [2:0] ST_D3   = 3'd5;
   localparam logic [2:0] ST_STAT = 3'd6;

   // Day offsets of the 400-year eras starting in 2000 and 1600 from 1970.
   localparam logic [20:0] ERA5_BIAS = 21'd11017;
   localparam logic [20:0] ERA4_BIAS = 21'd1962072;

   logic [2:0]  state_ff, state_in;
   entry_type   ent_ff, ent_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  mon_ff, mon_in;
   logic [16:0] days_ff, days_in;
   logic [33:0] secs_ff, secs_in;
   logic [63:0] t_ff, t_in;
   logic [63:0] prev_ff, prev_in;
   logic        prev_valid_ff, prev_valid_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_kind_ff, out_kind_in;
   logic signed [16:0] out_value_ff, out_value_in;
   logic [9:0]         out_index_ff, out_index_in;
   logic [1:0]         out_status_ff, out_status_in;
   logic [62:0]        out_time_ff, out_time_in;
   logic               out_last_ff, out_last_in;

   logic        out_free;
   logic        load;

   // Month arithmetic.
   logic [7:0]  mx;
   logic [15:0] mprod;
   logic [4:0]  mq;
   logic [3:0]  mr;
   // Day arithmetic.
   logic [11:0] yy;
   logic        era5;
   logic [8:0]  yoe;
   logic [3:0]  mp;
   logic [1:0]  cent;
   logic [20:0] doe;
   logic [20:0] days_full;
   // Status check.
   logic [63:0] t_diff;
   logic [1:0]  status;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      // Month number minus one, split by twelve with a reciprocal.
      mx    = ent_ff.hdr[1] - 8'd1;
      mprod = 16'(mx) * 16'd171;
      mq    = mprod[15:11];
      mr    = 4'(mx - 8'(mq) * 8'd12);
      if (ent_ff.hdr[1] == 8'd0) begin
         year_in = 12'(ent_ff.hdr[0]) + 12'd1999;
         mon_in  = 4'd12;
      end else begin
         year_in = 12'(ent_ff.hdr[0]) + 12'd2000 + 12'(mq);
         mon_in  = mr + 4'd1;
      end

      yy   = (mon_ff <= 4'd2) ? year_ff - 12'd1 : year_ff;
      era5 = yy >= 12'd2000;
      yoe  = 9'(yy - (era5 ? 12'd2000 : 12'd1600));
      mp   = (mon_ff > 4'd2) ? mon_ff - 4'd3 : mon_ff + 4'd9;
      if (yoe >= 9'd300) begin
         cent = 2'd3;
      end else if (yoe >= 9'd200) begin
         cent = 2'd2;
      end else if (yoe >= 9'd100) begin
         cent = 2'd1;
      end else begin
         cent = 2'd0;
      end
      doe = 21'(yoe) * 21'd365 + 21'(yoe[8:2]) - 21'(cent) + 21'(spdc_doy(mp));
      days_full = doe + 21'(ent_ff.hdr[2]) - 21'd1 + (era5 ? ERA5_BIAS : ERA4_BIAS);
      days_in   = days_full[16:0];

      secs_in = 34'(days_ff) * 34'd86400 + 34'(ent_ff.hdr[3]) * 34'd3600
              + 34'(ent_ff.hdr[4]) * 34'd60 + 34'(ent_ff.hdr[5]);
      t_in = 64'(secs_ff) * 64'd1000000
           + 64'({ent_ff.hdr[6], ent_ff.hdr[7], ent_ff.hdr[8], ent_ff.hdr[9]});

      t_diff = t_ff - prev_ff;
      if (prev_valid_ff && (t_diff != {32'd0, time_increment_us})) begin
         status = STATUS_BAD_TIME;
      end else if (ent_ff.count != {1'b0, expected_length}) begin
         status = STATUS_BAD_LEN;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ent_in        = ent_ff;
      q_pop         = 1'b0;
      load          = 1'b0;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      out_kind_in   = out_kind_ff;
      out_value_in  = out_value_ff;
      out_index_in  = out_index_ff;
      out_status_in = out_status_ff;
      out_time_in   = out_time_ff;
      out_last_in   = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               ent_in = q_data;
               if (q_data.has_sample) begin
                  state_in = ST_SMP;
               end else if (q_data.has_status) begin
                  state_in = ST_D0;
               end
            end
         end
         ST_SMP: begin
            if (out_free) begin
               load          = 1'b1;
               out_kind_in   = KIND_SAMPLE;
               out_value_in  = signed'(17'({1'b0, ent_ff.raw} - {1'b0, offset_value}));
               out_index_in  = ent_ff.index;
               out_status_in = STATUS_OK;
               out_time_in   = '0;
               out_last_in   = !ent_ff.has_status;
               state_in      = ent_ff.has_status ? ST_D0 : ST_IDLE;
            end
         end
         ST_D0:   state_in = ST_D1;
         ST_D1:   state_in = ST_D2;
         ST_D2:   state_in = ST_D3;
         ST_D3:   state_in = ST_STAT;
         ST_STAT: begin
            if (out_free) begin
               load          = 1'b1;
               out_kind_in   = KIND_STATUS;
               out_value_in  = '0;
               out_index_in  = '0;
               out_status_in = status;
               out_time_in   = t_ff[62:0];
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
               if (status == STATUS_OK) begin
                  prev_in       = t_ff;
                  prev_valid_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_valid_in = load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff        <= ent_in;
      out_kind_ff   <= out_kind_in;
      out_value_ff  <= out_value_in;
      out_index_ff  <= out_index_in;
      out_status_ff <= out_status_in;
      out_time_ff   <= out_time_in;
      out_last_ff   <= out_last_in;
      if (state_ff == ST_D0) begin
         year_ff <= year_in;
         mon_ff  <= mon_in;
      end
      if (state_ff == ST_D1) begin
         days_ff <= days_in;
      end
      if (state_ff == ST_D2) begin
         secs_ff <= secs_in;
      end
      if (state_ff == ST_D3) begin
         t_ff <= t_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_sample_value   = out_value_ff;
   assign rsp_sample_index   = out_index_ff;
   assign rsp_packet_status  = out_status_ff;
   assign rsp_packet_time_us = out_time_ff;
   assign rsp_last_of_run    = out_last_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("queue popped while busy");
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STAT && out_free) |=> rsp_valid && rsp_last_of_run
      && rsp_result_kind == KIND_STATUS) else $error("status beat malformed");
   a_good_updates: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STAT && out_free && status == STATUS_OK) |=> prev_valid_ff)
      else $error("good packet did not set previous time");
   a_decode_runs: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_D1 |=> state_ff == ST_D2) else $error("decode sequence broken");

endmodule

[hw/rtl/sample_packet_deframe_check.sv]
// ----------------------------------------------------------------------------
// sample_packet_deframe_check
// Deframes time-stamped sample packets and checks time and length.
//
//   channel | ports                        | direction
//   req     | req_valid/req_stall + fields | in, one byte per beat
//   rsp     | rsp_valid/rsp_stall + fields | out, sample or status beat
//   csr     | csr_write_en, index, wdata   | in, register writes
//
// The front takes one byte per cycle and stalls only when the queue is full.
// The back takes a new queue entry only once the last is out; the status
// time decode runs through four registered steps before the status beat.
// Reset is synchronous; it clears positions, queue, previous time and output.
// A stalled result holds in the output register while the front keeps going.
// ----------------------------------------------------------------------------
module sample_packet_deframe_check import spdc_pkg::*; #(
   parameter int HEADER_BYTES       = HEADER_BYTES_DEFAULT,
   parameter int SAMPLES_PER_PACKET = SAMPLES_PER_PACKET_DEFAULT,
   parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_packet,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic signed [16:0] rsp_sample_value,
   output logic [9:0]         rsp_sample_index,
   output logic [1:0]         rsp_packet_status,
   output logic [62:0]        rsp_packet_time_us,
   output logic               rsp_last_of_run,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   logic [31:0] time_inc_ff;
   logic [15:0] offset_ff;
   logic [11:0] exp_len_ff;

   logic      accept;
   logic      push;
   entry_type push_data;
   logic      pop;
   entry_type pop_data;
   logic      q_full;
   logic      q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_inc_ff <= '0;
         offset_ff   <= 16'd32768;
         exp_len_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TIME_INC:   time_inc_ff <= csr_wdata;
            CSR_OFFSET:     offset_ff   <= csr_wdata[15:0];
            CSR_EXP_LENGTH: exp_len_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   spdc_front #(
      .HEADER_BYTES       (HEADER_BYTES),
      .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_packet (req_end_of_packet),
      .push          (push),
      .entry         (push_data)
   );

   spdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   spdc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .time_increment_us  (time_inc_ff),
      .offset_value       (offset_ff),
      .expected_length    (exp_len_ff),
      .q_empty            (q_empty),
      .q_data             (pop_data),
      .q_pop              (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_sample_value   (rsp_sample_value),
      .rsp_sample_index   (rsp_sample_index),
      .rsp_packet_status  (rsp_packet_status),
      .rsp_packet_time_us (rsp_packet_time_us),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
